FILE: rtl/core/ptht_pkg.sv
// Shared types and constants for the pointer tracking hash table core.
package ptht_pkg;

	// Command codes carried in the input beat.
	localparam logic [1:0] CMD_INSERT        = 2'd0;
	localparam logic [1:0] CMD_RELEASE_USER  = 2'd1;
	localparam logic [1:0] CMD_RELEASE_GUARD = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_UNTRACKED = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_HASH_SHIFT   = 1'b0;
	localparam logic CFG_GUARD_OFFSET = 1'b1;

	// Home slot reduction walks the shifted address one nibble per cycle.
	localparam int HASH_DIGIT_W   = 4;
	localparam int HASH_STEPS     = 64 / HASH_DIGIT_W;
	localparam int HASH_STEP_CNT_W = 4;

	// One stored allocation record.
	typedef struct packed {
		logic [63:0] user_address;
		logic [63:0] original_address;
		logic [63:0] byte_size;
	} entry_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/pointer_tracking_hash_table_core.sv
// Steps: accept, home slot reduction, probing from the home slot, result beat.
// One probe per cycle on the record memory read port.
// One command is handled at a time; a new beat is taken once the result beat has gone.
// After reset the core sweeps the record memory, one slot per cycle, before it accepts
// its first beat. Registers reset to shift 4 and guard 16.
module pointer_tracking_hash_table_core #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [11:0]   cfg_data,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// command[1:0], user_address[65:2], original_address[129:66],
	// element_count[161:130], element_bytes[193:162], zero fill[199:194]
	input  logic [199:0]  s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// status[1:0], slot_index[7:2], released_original[71:8], released_bytes[135:72]
	output logic [135:0]  m_axis_tdata
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

	ptht_pkg::state_t state_q, state_d;

	logic [3:0]    hash_shift_q;
	logic [11:0]   guard_offset_q;

	logic [1:0]    cmd_q;
	logic [63:0]   user_q;
	logic [63:0]   orig_q;
	logic [31:0]   count_q;
	logic [31:0]   ebytes_q;
	logic [63:0]   key_q;
	logic [63:0]   prod_q;

	logic [SW-1:0] clr_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] n_q;
	logic [SW-1:0] next_slot;

	logic [1:0]    res_status_q, res_status_d;
	logic [5:0]    res_slot_q, res_slot_d;
	logic [63:0]   res_orig_q, res_orig_d;
	logic [63:0]   res_bytes_q, res_bytes_d;
	logic          res_load;

	logic          accept;
	logic          hash_start, hash_done;
	logic [SW-1:0] hash_slot;
	logic [63:0]   in_user;

	logic             we;
	logic [SW-1:0]    waddr, raddr;
	ptht_pkg::entry_t wentry, rentry;

	logic          slot_empty, slot_hit, advance;
	logic [63:0]   have;

	assign in_user = s_axis_tdata[65:2];
	assign accept  = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_shift_q   <= 4'd4;
			guard_offset_q <= 12'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				ptht_pkg::CFG_HASH_SHIFT:   hash_shift_q   <= cfg_data[3:0];
				ptht_pkg::CFG_GUARD_OFFSET: guard_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Home slot unit, started with the shifted address of the accepted beat.
	ptht_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.value  (in_user >> hash_shift_q),
		.done   (hash_done),
		.slot   (hash_slot)
	);

	ptht_store #(.TABLE_SLOTS(TABLE_SLOTS)) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wentry (wentry),
		.raddr  (raddr),
		.rentry (rentry)
	);

	// Probe compare on the entry read in the previous cycle.
	assign next_slot  = (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;
	assign slot_empty = (rentry.user_address == 64'd0);
	assign have       = (cmd_q == ptht_pkg::CMD_RELEASE_GUARD) ? rentry.original_address
	                                                           : rentry.user_address;
	assign slot_hit   = !slot_empty && (have == key_q);

	// Next state, memory control and result selection.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		hash_start    = 1'b0;
		we            = 1'b0;
		waddr         = cur_q;
		wentry        = '0;
		raddr         = cur_q;
		advance       = 1'b0;
		res_load      = 1'b0;
		res_status_d  = ptht_pkg::STATUS_UNTRACKED;
		res_slot_d    = '0;
		res_orig_d    = '0;
		res_bytes_d   = '0;
		case (state_q)
			ptht_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == LAST_SLOT) begin
					state_d = ptht_pkg::ST_IDLE;
				end
			end
			ptht_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tdata[1:0] == ptht_pkg::CMD_INSERT ||
					    s_axis_tdata[1:0] == ptht_pkg::CMD_RELEASE_GUARD ||
					    (s_axis_tdata[1:0] == ptht_pkg::CMD_RELEASE_USER &&
					     in_user != 64'd0)) begin
						hash_start = 1'b1;
						state_d    = ptht_pkg::ST_HASH;
					end else begin
						res_load = 1'b1;
						state_d  = ptht_pkg::ST_OUT;
					end
				end
			end
			ptht_pkg::ST_HASH: begin
				raddr = hash_slot;
				if (hash_done) begin
					state_d = ptht_pkg::ST_PROBE;
				end
			end
			ptht_pkg::ST_PROBE: begin
				raddr = next_slot;
				if (cmd_q == ptht_pkg::CMD_INSERT) begin
					if (slot_empty) begin
						we           = 1'b1;
						wentry       = '{user_address: user_q, original_address: orig_q,
						                 byte_size: prod_q};
						res_load     = 1'b1;
						res_status_d = ptht_pkg::STATUS_DONE;
						res_slot_d   = 6'(cur_q);
						state_d      = ptht_pkg::ST_OUT;
					end else if (n_q == LAST_SLOT) begin
						res_load     = 1'b1;
						res_status_d = ptht_pkg::STATUS_FULL;
						state_d      = ptht_pkg::ST_OUT;
					end else begin
						advance = 1'b1;
					end
				end else begin
					if (slot_hit) begin
						we           = 1'b1;
						res_load     = 1'b1;
						res_status_d = ptht_pkg::STATUS_DONE;
						res_slot_d   = 6'(cur_q);
						res_orig_d   = rentry.original_address;
						res_bytes_d  = rentry.byte_size;
						state_d      = ptht_pkg::ST_OUT;
					end else if (slot_empty || n_q == LAST_SLOT) begin
						res_load = 1'b1;
						state_d  = ptht_pkg::ST_OUT;
					end else begin
						advance = 1'b1;
					end
				end
			end
			ptht_pkg::ST_OUT: begin
				if (m_axis_tready) begin
					state_d = ptht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptht_pkg::ST_IDLE;
			end
		endcase
	end

	// State register and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptht_pkg::ST_CLEAR;
			clr_q   <= '0;
			cur_q   <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ptht_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ptht_pkg::ST_HASH) begin
				cur_q <= hash_slot;
				n_q   <= '0;
			end else if (advance) begin
				cur_q <= next_slot;
				n_q   <= n_q + 1'b1;
			end
		end
	end

	// Captured beat, match key and byte size product.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_axis_tdata[1:0];
			user_q   <= in_user;
			orig_q   <= s_axis_tdata[129:66];
			count_q  <= s_axis_tdata[161:130];
			ebytes_q <= s_axis_tdata[193:162];
			key_q    <= (s_axis_tdata[1:0] == ptht_pkg::CMD_RELEASE_GUARD)
			            ? in_user - {52'd0, guard_offset_q} : in_user;
		end
		if (state_q == ptht_pkg::ST_HASH) begin
			prod_q <= 64'(count_q) * 64'(ebytes_q);
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_orig_q   <= res_orig_d;
			res_bytes_q  <= res_bytes_d;
		end
	end

	assign m_axis_tvalid = (state_q == ptht_pkg::ST_OUT);
	assign m_axis_tdata  = {res_bytes_q, res_orig_q, res_slot_q, res_status_q};

`ifndef NO_ASSERTIONS
	// Only one command is in flight: no input beat is taken while a result waits.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while a result is pending");

	// The memory is written only by the clearing sweep or by a finished probe.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ptht_pkg::ST_CLEAR || state_q == ptht_pkg::ST_PROBE))
		else $error("record memory written outside sweep or probe");

	// A probe that writes always ends the command.
	a_write_ends_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q == ptht_pkg::ST_PROBE) |=> (state_q == ptht_pkg::ST_OUT))
		else $error("probe write did not produce a result");

	// A result beat follows the home slot completion only through probing.
	a_hash_to_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptht_pkg::ST_HASH && hash_done) |=> (state_q == ptht_pkg::ST_PROBE))
		else $error("home slot ready but probing did not start");
`endif

endmodule

FILE: rtl/core/ptht_hash.sv
// Iterative home slot unit: (value mod TABLE_SLOTS) with one compare-subtract per bit.
module ptht_hash #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [63:0]                      value,
	output logic                             done,
	output logic [$clog2(TABLE_SLOTS)-1:0]   slot
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam logic [SW:0] SLOTS_X = (SW+1)'(TABLE_SLOTS);

	logic [63:0]                           val_q;
	logic [SW-1:0]                         rem_q;
	logic [ptht_pkg::HASH_STEP_CNT_W-1:0]  cnt_q;
	logic                                  busy_q;
	logic                                  done_q;

	// Fold four address bits into the running remainder, most significant first.
	function automatic logic [SW-1:0] reduce_digit(
		input logic [SW-1:0]                       r,
		input logic [ptht_pkg::HASH_DIGIT_W-1:0]   d
	);
		logic [SW:0] t;
		t = {1'b0, r};
		for (int i = ptht_pkg::HASH_DIGIT_W - 1; i >= 0; i--) begin
			t = {t[SW-1:0], d[i]};
			if (t >= SLOTS_X) begin
				t = t - SLOTS_X;
			end
		end
		return t[SW-1:0];
	endfunction

	// Control of the reduction loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ptht_pkg::HASH_STEP_CNT_W'(ptht_pkg::HASH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and remaining address bits.
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= reduce_digit(rem_q, val_q[63 -: ptht_pkg::HASH_DIGIT_W]);
			val_q <= val_q << ptht_pkg::HASH_DIGIT_W;
		end
	end

	assign done = done_q;
	assign slot = rem_q;

endmodule

FILE: rtl/core/ptht_store.sv
// Record memory: one write port and one registered read port.
module ptht_store #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(TABLE_SLOTS)-1:0]   waddr,
	input  ptht_pkg::entry_t                 wentry,
	input  logic [$clog2(TABLE_SLOTS)-1:0]   raddr,
	output ptht_pkg::entry_t                 rentry
);

	ptht_pkg::entry_t mem [TABLE_SLOTS];
	ptht_pkg::entry_t rentry_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wentry;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rentry_q <= mem[raddr];
	end

	assign rentry = rentry_q;

endmodule
